FILE: rtl/core/dcc_pkg.sv
// Shared types, codes and format helpers for the delta column codec.
`default_nettype none

package dcc_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_DIRECTION = 2'd0;
    localparam logic [1:0] REG_COL_COUNT = 2'd1;
    localparam logic [1:0] REG_COL_FMTS  = 2'd2;

    // Direction codes.
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Result error codes.
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_RANGE    = 2'd2;

    // Field widths fixed by the stream format.
    localparam int DATA_W     = 64;
    localparam int FMTS_W     = 56;
    localparam int COL_FMT_W  = 7;
    localparam int COUNT_W    = 4;
    localparam int COL_IDX_W  = 3;
    localparam int ERR_W      = 2;
    localparam int CFG_IDX_W  = 2;

    // Size exponent codes.
    localparam logic [1:0] EXP_1B = 2'd0;
    localparam logic [1:0] EXP_2B = 2'd1;
    localparam logic [1:0] EXP_4B = 2'd2;
    localparam logic [1:0] EXP_8B = 2'd3;

    // Per-column format, bit 0 at the bottom.
    typedef struct packed {
        logic       dlt_sgn;
        logic [1:0] dlt_exp;
        logic       dlt_on;
        logic       val_sgn;
        logic [1:0] val_exp;
    } t_col_fmt;

    // Result of one item from the codec unit.
    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] byte_count;
        logic [ERR_W-1:0]   err;
    } t_codec_res;

    // Mask of the low bytes selected by a size exponent.
    function automatic logic [DATA_W-1:0] low_mask(input logic [1:0] e);
        logic [DATA_W-1:0] m;
        case (e)
            EXP_1B:  m = 64'h0000_0000_0000_00FF;
            EXP_2B:  m = 64'h0000_0000_0000_FFFF;
            EXP_4B:  m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Byte count of a size exponent.
    function automatic logic [COUNT_W-1:0] size_bytes(input logic [1:0] e);
        logic [COUNT_W-1:0] n;
        case (e)
            EXP_1B:  n = 4'd1;
            EXP_2B:  n = 4'd2;
            EXP_4B:  n = 4'd4;
            default: n = 4'd8;
        endcase
        return n;
    endfunction

    // Keep the low bytes and sign- or zero-extend them to the full word.
    function automatic logic [DATA_W-1:0] extend(input logic [DATA_W-1:0] x,
                                                 input logic sgn,
                                                 input logic [1:0] e);
        logic [DATA_W-1:0] m;
        logic              top;
        m = low_mask(e);
        case (e)
            EXP_1B:  top = x[7];
            EXP_2B:  top = x[15];
            EXP_4B:  top = x[31];
            default: top = x[63];
        endcase
        return (sgn && top) ? (x | ~m) : (x & m);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dcc_codec_unit.sv
// Combinational encode and decode of one column item against its previous value.
`default_nettype none

module dcc_codec_unit import dcc_pkg::*; (
    input  wire logic              i_decode,
    input  wire t_col_fmt          i_fmt,
    input  wire logic              i_first_row,
    input  wire logic [DATA_W-1:0] i_prev,
    input  wire logic [DATA_W-1:0] i_data,
    output t_codec_res             o_res,
    output logic                   o_prev_we,
    output logic [DATA_W-1:0]      o_prev_data
);

    logic              use_delta;
    logic [1:0]        e;
    logic              sgn;
    logic [DATA_W-1:0] mask;
    logic [DATA_W+1:0] x_ext;
    logic [DATA_W+1:0] p_ext;
    logic [DATA_W+1:0] diff;
    logic [DATA_W-1:0] enc_val;
    logic              enc_ovf;
    logic              enc_fits;
    logic [DATA_W-1:0] dec_d;
    logic [DATA_W+1:0] d_ext;
    logic [DATA_W+1:0] sum;
    logic              dec_ovf;
    logic [DATA_W-1:0] dec_val;

    // Delta coding applies from the second row on.
    assign use_delta = i_fmt.dlt_on && !i_first_row;
    assign e         = use_delta ? i_fmt.dlt_exp : i_fmt.val_exp;
    assign sgn       = use_delta ? i_fmt.dlt_sgn : i_fmt.val_sgn;
    assign mask      = low_mask(e);

    // Previous value widened by two bits in the column's value type.
    assign p_ext = {{2{i_fmt.val_sgn & i_prev[DATA_W-1]}}, i_prev};

    // Encode: exact difference, then checks against the delta and output types.
    assign x_ext   = {{2{i_fmt.val_sgn & i_data[DATA_W-1]}}, i_data};
    assign diff    = x_ext - p_ext;
    assign enc_val = use_delta ? diff[DATA_W-1:0] : i_data;

    always_comb begin
        if (!use_delta) begin
            enc_ovf = 1'b0;
        end else if (i_fmt.dlt_sgn) begin
            enc_ovf = !(diff[DATA_W+1:DATA_W-1] == 3'b000 ||
                        diff[DATA_W+1:DATA_W-1] == 3'b111);
        end else begin
            enc_ovf = (diff[DATA_W+1:DATA_W] != 2'b00);
        end
    end

    assign enc_fits = sgn ? (extend(enc_val, 1'b1, e) == enc_val)
                          : ((enc_val & ~mask) == '0);

    // Decode: extend the bytes, then an exact sum checked against the value type.
    assign dec_d   = extend(i_data, sgn, e);
    assign d_ext   = {{2{i_fmt.dlt_sgn & dec_d[DATA_W-1]}}, dec_d};
    assign sum     = p_ext + d_ext;
    assign dec_val = use_delta ? sum[DATA_W-1:0] : dec_d;

    always_comb begin
        if (!use_delta) begin
            dec_ovf = 1'b0;
        end else if (i_fmt.val_sgn) begin
            dec_ovf = !(sum[DATA_W+1:DATA_W-1] == 3'b000 ||
                        sum[DATA_W+1:DATA_W-1] == 3'b111);
        end else begin
            dec_ovf = (sum[DATA_W+1:DATA_W] != 2'b00);
        end
    end

    // Result selection; a failed item carries zero data.
    always_comb begin
        o_res.byte_count = size_bytes(e);
        if (i_decode == DIR_DECODE) begin
            o_res.err   = dec_ovf ? ERR_OVERFLOW : ERR_OK;
            o_res.data  = dec_ovf ? '0 : dec_val;
            o_prev_we   = i_fmt.dlt_on && !dec_ovf;
            o_prev_data = dec_val;
        end else begin
            if (enc_ovf) begin
                o_res.err = ERR_OVERFLOW;
            end else if (!enc_fits) begin
                o_res.err = ERR_RANGE;
            end else begin
                o_res.err = ERR_OK;
            end
            o_res.data  = (enc_ovf || !enc_fits) ? '0 : (enc_val & mask);
            o_prev_we   = i_fmt.dlt_on;
            o_prev_data = i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/delta_column_codec.sv
// Top level of the delta column codec: request registers, column state and handshakes.
// Usage:
//   The input stream carries one 64-bit word per column item on s_axis_*. In encode
//   mode the word is the column value; in decode mode it holds the little-endian
//   bytes of the coded item, low-aligned. Items run row by row, column by column.
//   The output stream returns one result per item on m_axis_*: the coded bytes or
//   the decoded value, the byte count and column index in tdata, the row end on
//   tlast and the error code on tuser. A failed item carries zero data.
//   The configuration channel writes direction, column count and column formats;
//   writes are always taken and must be made while no item is in flight.
// Timing:
//   An accepted request lands in the input register; the codec unit computes it and
//   the result register loads it once that register is free or being read.
//   While the receiver keeps up, one item is accepted per cycle; the combinational
//   subtract or add with its overflow and width checks sets that rate, and it also
//   updates the column's previous value, which the next item of any column sees at once.
// Reset and stall:
//   Reset empties both registers, clears the previous values and the column counter,
//   and marks the first row. When the receiver stalls, the result register holds and
//   the input register takes one more request before s_axis_tready drops.
`default_nettype none

module delta_column_codec import dcc_pkg::*; #(
    parameter int MAX_COLUMNS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input stream. tdata: data_in[63:0].
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [DATA_W-1:0]    s_axis_tdata,
    // Output stream. tdata: data_out[63:0], byte_count[67:64], column_index[70:68],
    // zero pad[71]. tuser: error_code[1:0]. tlast: row_end.
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [71:0]               m_axis_tdata,
    output logic [ERR_W-1:0]          m_axis_tuser,
    output logic                      m_axis_tlast,
    // Configuration write channel.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [FMTS_W-1:0]    i_cfg_data
);

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    // Configuration registers.
    logic               r_direction;
    logic [COUNT_W-1:0] r_col_count;
    logic [FMTS_W-1:0]  r_col_fmts;

    // Column state.
    logic [DATA_W-1:0]    r_prev [MAX_COLUMNS];
    logic [COL_IDX_W-1:0] r_cur_col;
    logic [COL_IDX_W-1:0] n_cur_col;
    logic                 r_first_row;

    // Input and result registers.
    logic                 r_in_valid;
    logic [DATA_W-1:0]    r_in_data;
    logic                 r_out_valid;
    t_codec_res           r_out_res;
    logic [COL_IDX_W-1:0] r_out_col;
    logic                 r_out_last;

    logic                 advance;
    logic                 in_take;
    logic [COUNT_W-1:0]   count_eff;
    logic [COUNT_W-1:0]   col_next;
    logic                 row_end;
    t_col_fmt             cur_fmt;
    logic [DATA_W-1:0]    cur_prev;
    t_codec_res           res;
    logic                 prev_we;
    logic [DATA_W-1:0]    prev_data;

    // Handshakes: the input register moves on whenever the result register frees.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DIR_ENCODE;
            r_col_count <= 4'd1;
            r_col_fmts  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DIRECTION: r_direction <= i_cfg_data[0];
                REG_COL_COUNT: r_col_count <= i_cfg_data[COUNT_W-1:0];
                REG_COL_FMTS:  r_col_fmts  <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Column count clamped to the supported range.
    always_comb begin
        if (r_col_count == '0) begin
            count_eff = 4'd1;
        end else if (r_col_count > COUNT_W'(MAX_COLUMNS)) begin
            count_eff = COUNT_W'(MAX_COLUMNS);
        end else begin
            count_eff = r_col_count;
        end
    end

    assign col_next  = {1'b0, r_cur_col} + 4'd1;
    assign row_end   = (col_next >= count_eff);
    assign n_cur_col = row_end ? '0 : col_next[COL_IDX_W-1:0];
    assign cur_fmt   = t_col_fmt'(r_col_fmts[COL_FMT_W*r_cur_col +: COL_FMT_W]);
    assign cur_prev  = r_prev[r_cur_col[COL_W-1:0]];

    dcc_codec_unit u_codec (
        .i_decode    (r_direction),
        .i_fmt       (cur_fmt),
        .i_first_row (r_first_row),
        .i_prev      (cur_prev),
        .i_data      (r_in_data),
        .o_res       (res),
        .o_prev_we   (prev_we),
        .o_prev_data (prev_data)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= s_axis_tdata;
        end
    end

    // Column counter, first-row flag and previous values advance with each item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col   <= '0;
            r_first_row <= 1'b1;
            for (int i = 0; i < MAX_COLUMNS; i++) begin
                r_prev[i] <= '0;
            end
        end else if (advance) begin
            r_cur_col <= n_cur_col;
            if (row_end) begin
                r_first_row <= 1'b0;
            end
            if (prev_we) begin
                r_prev[r_cur_col[COL_W-1:0]] <= prev_data;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_res  <= res;
            r_out_col  <= r_cur_col;
            r_out_last <= row_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_col, r_out_res.byte_count, r_out_res.data};
    assign m_axis_tuser  = r_out_res.err;
    assign m_axis_tlast  = r_out_last;

    // A failed item never carries data.
    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ERR_OK) |-> (m_axis_tdata[DATA_W-1:0] == '0))
        else $error("failed item carries nonzero data");

    // The byte count is always one of the four format sizes.
    a_count_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot(m_axis_tdata[67:64]))
        else $error("byte count is not a format size");

    // Column indexes stay inside the stored columns.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[70:68]) < MAX_COLUMNS))
        else $error("column index beyond stored columns");

    // Within a row the column counter steps by one per item.
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !row_end) |=> (r_cur_col == $past(r_cur_col) + 3'd1))
        else $error("column counter skipped");

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the delta column codec: directed and random column streams.
module tb import dcc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_COLS     = 8;
    localparam int          TARGET_ITEMS = 1150;
    localparam int          LIMIT_CYCLES = 300000;
    localparam logic [1:0]  REG_UNUSED   = 2'd3;

    // Expected outcome of one column item.
    typedef struct {
        logic [DATA_W-1:0]    data;
        logic [COUNT_W-1:0]   nbytes;
        logic [COL_IDX_W-1:0] col;
        logic                 last;
        logic [ERR_W-1:0]     err;
    } t_col_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_W-1:0]    s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [71:0]          m_axis_tdata;
    logic [ERR_W-1:0]     m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [FMTS_W-1:0]    i_cfg_data = '0;

    // Shadow copy of the codec registers and column state.
    logic                 cfg_dir = DIR_ENCODE;
    logic [COUNT_W-1:0]   cfg_count = 4'd1;
    logic [FMTS_W-1:0]    cfg_fmts = '0;
    logic [DATA_W-1:0]    prev_vals [MAX_COLS];
    logic [COL_IDX_W-1:0] cur_col = '0;
    logic                 first_row_flag = 1'b1;

    logic [DATA_W-1:0]    pending_words [$];
    t_col_result          due_results [$];
    bit                   word_taken = 1'b0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   mismatches = 0;
    int                   results_checked = 0;
    int                   overflow_seen = 0;
    int                   range_seen = 0;
    int                   items_queued = 0;
    int                   settings_used = 0;
    int                   cycle_count = 0;

    delta_column_codec #(
        .MAX_COLUMNS(MAX_COLS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        foreach (prev_vals[i]) prev_vals[i] = '0;
    end

    // All ones in the bytes that a size exponent selects.
    function automatic logic [DATA_W-1:0] byte_mask(input logic [1:0] e);
        return (e == EXP_8B) ? '1 : ((64'd1 << (8 << e)) - 64'd1);
    endfunction

    // Truncate to the selected bytes and extend back to 64 bits.
    function automatic logic [DATA_W-1:0] narrow(input logic [DATA_W-1:0] x,
                                                 input logic sgn,
                                                 input logic [1:0] e);
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] y;
        m = byte_mask(e);
        y = x & m;
        if (sgn && e != EXP_8B && y[(8 << e) - 1]) y = y | ~m;
        return y;
    endfunction

    // Exact 66-bit view of a 64-bit word, signed or unsigned.
    function automatic logic signed [65:0] widen(input logic [DATA_W-1:0] x, input logic sgn);
        return sgn ? {{2{x[63]}}, x} : {2'b00, x};
    endfunction

    function automatic bit in_range(input logic signed [65:0] s, input logic sgn);
        if (sgn) return s[65:63] == 3'b000 || s[65:63] == 3'b111;
        return s[65:64] == 2'b00;
    endfunction

    // Column count as the block applies it: zero acts as one, large values saturate.
    function automatic int eff_count();
        int n;
        n = int'(cfg_count);
        if (n < 1) n = 1;
        if (n > MAX_COLS) n = MAX_COLS;
        return n;
    endfunction

    function automatic t_col_fmt col_fmt(input logic [1:0] ve, input logic vs, input logic dl,
                                         input logic [1:0] de, input logic ds);
        return '{dlt_sgn: ds, dlt_exp: de, dlt_on: dl, val_sgn: vs, val_exp: ve};
    endfunction

    // Code one column item against the shadow state and advance that state.
    function automatic t_col_result code_column_item(input logic [DATA_W-1:0] x);
        t_col_fmt          f;
        logic              use_delta;
        logic [1:0]        e;
        logic              sgn;
        logic signed [65:0] exact;
        logic [DATA_W-1:0] val;
        t_col_result       r;
        f = t_col_fmt'(cfg_fmts[7 * cur_col +: COL_FMT_W]);
        use_delta = f.dlt_on && !first_row_flag;
        e = use_delta ? f.dlt_exp : f.val_exp;
        sgn = use_delta ? f.dlt_sgn : f.val_sgn;
        r.data = '0;
        r.err = ERR_OK;
        r.nbytes = 4'd1 << e;
        r.col = cur_col;
        r.last = (int'(cur_col) + 1) >= eff_count();
        if (cfg_dir == DIR_ENCODE) begin
            val = x;
            if (use_delta) begin
                exact = widen(x, f.val_sgn) - widen(prev_vals[cur_col], f.val_sgn);
                if (!in_range(exact, f.dlt_sgn)) r.err = ERR_OVERFLOW;
                val = exact[63:0];
            end
            if (r.err == ERR_OK && narrow(val, sgn, e) != val) r.err = ERR_RANGE;
            if (r.err == ERR_OK) r.data = val & byte_mask(e);
            // The raw value is remembered even when the item fails.
            if (f.dlt_on) prev_vals[cur_col] = x;
        end else begin
            val = narrow(x, sgn, e);
            if (use_delta) begin
                exact = widen(prev_vals[cur_col], f.val_sgn) + widen(val, f.dlt_sgn);
                if (!in_range(exact, f.val_sgn)) r.err = ERR_OVERFLOW;
                else val = exact[63:0];
            end
            if (r.err == ERR_OK) begin
                r.data = val;
                if (f.dlt_on) prev_vals[cur_col] = val;
            end
        end
        if (r.last) begin
            cur_col = '0;
            first_row_flag = 1'b0;
        end else begin
            cur_col = cur_col + 3'd1;
        end
        return r;
    endfunction

    // Random input word: extremes, full words, short values, or in encode a sign-extended step from the base.
    function automatic logic [DATA_W-1:0] gen_word(input logic [DATA_W-1:0] base, input logic dir);
        logic [DATA_W-1:0] rnd;
        logic [1:0]        e;
        int                pick;
        rnd = {$urandom, $urandom};
        e = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return '1;
                2: return 64'h8000_0000_0000_0000;
                default: return 64'h7FFF_FFFF_FFFF_FFFF;
            endcase
        end
        if (pick < 3) return rnd;
        if (dir == DIR_ENCODE && pick < 10) return base + narrow(rnd, 1'b1, e);
        return narrow(rnd, 1'($urandom_range(0, 1)), e);
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Register write; the caller lowers the valid after its last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FMTS_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_DIRECTION: cfg_dir = val[0];
            REG_COL_COUNT: cfg_count = val[COUNT_W-1:0];
            REG_COL_FMTS:  cfg_fmts = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Block until every queued word went in and every result came back.
    task automatic wait_idle();
        while (pending_words.size() != 0 || s_axis_tvalid || due_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic queue_words(input logic [DATA_W-1:0] words [$]);
        foreach (words[i]) pending_words.push_back(words[i]);
        items_queued += words.size();
    endtask

    // Input driver: a request holds until taken, then the next word or a gap follows.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || word_taken) begin
            word_taken = 1'b0;
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_axis_tdata  <= pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tdata  <= {$urandom, $urandom};
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: predict on every accepted request, compare every accepted result.
    always @(posedge i_clk) begin : monitor
        t_col_result want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                due_results.push_back(code_column_item(s_axis_tdata));
                word_taken = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, actual %h",
                             $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    check_field("data_out", want.data, m_axis_tdata[63:0]);
                    check_field("byte_count", 64'(want.nbytes), 64'(m_axis_tdata[67:64]));
                    check_field("column_index", 64'(want.col), 64'(m_axis_tdata[70:68]));
                    check_field("tdata pad", 64'd0, 64'(m_axis_tdata[71]));
                    check_field("row_end", 64'(want.last), 64'(m_axis_tlast));
                    check_field("error_code", 64'(want.err), 64'(m_axis_tuser));
                    results_checked++;
                    if (want.err == ERR_OVERFLOW) overflow_seen++;
                    if (want.err == ERR_RANGE) range_seen++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, due_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        logic [FMTS_W-1:0] fmts;
        logic [DATA_W-1:0] gen_base [MAX_COLS];
        int                gen_col;
        int                n;
        int                cfg_round;
        logic              dir;
        logic [DATA_W-1:0] w;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: one narrow unsigned column, so wide values fail the range check.
        queue_words({64'h0, 64'hFF, 64'h100, 64'hFFFF_FFFF_FFFF_FFFF});
        wait_idle();

        // Two delta columns in encode: overflow failures, then small steps.
        fmts = '0;
        fmts[6:0]  = col_fmt(EXP_8B, 1'b1, 1'b1, EXP_1B, 1'b1);
        fmts[13:7] = col_fmt(EXP_8B, 1'b0, 1'b1, EXP_8B, 1'b0);
        fmts[20:14] = col_fmt(EXP_2B, 1'b1, 1'b0, EXP_1B, 1'b0);
        fmts[27:21] = col_fmt(EXP_8B, 1'b1, 1'b1, EXP_8B, 1'b1);
        write_reg(REG_DIRECTION, FMTS_W'(DIR_ENCODE));
        write_reg(REG_COL_COUNT, 56'd2);
        write_reg(REG_COL_FMTS, fmts);
        i_cfg_valid <= 1'b0;
        settings_used++;
        queue_words({64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'h7FFF_FFFF_FFFF_FFFF, 64'h0,
                     64'h7FFF_FFFF_FFFF_FF80, 64'h5});
        wait_idle();

        // Decode with a zero column count, which acts as a single column.
        write_reg(REG_DIRECTION, FMTS_W'(DIR_DECODE));
        write_reg(REG_COL_COUNT, 56'd0);
        i_cfg_valid <= 1'b0;
        settings_used++;
        queue_words({64'hFFFF_FFFF_FFFF_FF80, 64'h7F});
        wait_idle();

        // Oversized count saturates; stop mid-row on column five.
        write_reg(REG_UNUSED, '1);
        write_reg(REG_COL_COUNT, 56'd15);
        i_cfg_valid <= 1'b0;
        settings_used++;
        queue_words({64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hABCD_8001,
                     64'h8000_0000_0000_0000, 64'h1234_56FF});
        wait_idle();

        // Shrinking the count leaves the current column past the row end.
        write_reg(REG_COL_COUNT, 56'd2);
        i_cfg_valid <= 1'b0;
        settings_used++;
        queue_words({64'hFF, 64'h0, 64'h1});
        wait_idle();

        // Random settings, each followed by a burst of column items.
        cfg_round = 0;
        while (items_queued < TARGET_ITEMS) begin
            case (cfg_round % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            dir = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: n = $urandom_range(9, 15);
                1: n = 0;
                default: n = $urandom_range(1, MAX_COLS);
            endcase
            w = {$urandom, $urandom};
            write_reg(REG_DIRECTION, {w[55:1], dir});
            w = {$urandom, $urandom};
            write_reg(REG_COL_COUNT, {w[55:4], 4'(n)});
            case ($urandom_range(0, 9))
                0: fmts = '0;
                1: fmts = '1;
                default: fmts = FMTS_W'({$urandom, $urandom});
            endcase
            write_reg(REG_COL_FMTS, fmts);
            if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, FMTS_W'({$urandom, $urandom}));
            i_cfg_valid <= 1'b0;
            settings_used++;

            // Steps follow each column's own history so that delta coding mostly succeeds.
            gen_col = int'(cur_col);
            foreach (gen_base[i]) gen_base[i] = prev_vals[i];
            n = $urandom_range(20, 70);
            repeat (n) begin
                w = gen_word(gen_base[gen_col], cfg_dir);
                if (cfg_dir == DIR_ENCODE) gen_base[gen_col] = w;
                gen_col = (gen_col + 1 >= eff_count()) ? 0 : gen_col + 1;
                pending_words.push_back(w);
            end
            items_queued += n;
            wait_idle();
            cfg_round++;
        end

        repeat (16) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, due_results.size());
            mismatches += due_results.size();
        end
        $display("Checked %0d column results from %0d items under %0d register settings.",
                 results_checked, items_queued, settings_used);
        $display("Failures flagged as expected: %0d overflow, %0d out of range.",
                 overflow_seen, range_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
